FILE: rtl/core/epc_pkg.sv
// epc_pkg: shared types and constants for the edge period pitch corrector
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package epc_pkg;

    // time counters and resistance widths
    localparam int TIME_W = 20;
    localparam int RES_W  = 10;
    localparam int CFG_W  = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // percent scale of the band
    localparam logic [7:0] PERCENT = 8'd100;

    // band product and compare widths
    localparam int BAND_W = 24;
    localparam int CMP_W  = 27;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_PERIOD  = 3'd0,
        CFG_ERROR_PERCENT  = 3'd1,
        CFG_EDGE_THRESHOLD = 3'd2,
        CFG_EDGE_HOLDOFF   = 3'd3,
        CFG_ADJUST_INTERVAL = 3'd4,
        CFG_MARGIN_STEPS   = 3'd5,
        CFG_FULL_SCALE     = 3'd6,
        CFG_CORR_ENABLE    = 3'd7
    } cfg_idx_t;

    // input word
    typedef struct packed {
        logic [7:0]       sample;
        logic [9:0]       delta_us;
        logic             note_active;
        logic             restart;
        logic             load_enable;
        logic [RES_W-1:0] load_value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [RES_W-1:0]  resistance;
        logic [TIME_W-1:0] average_period;
        logic              edge_seen;
        logic              new_average;
        logic              bottomed_out;
        logic              topped_out;
    } out_word_t;

    // configuration register set
    typedef struct packed {
        logic [15:0]       target_period_us;
        logic [5:0]        error_percent;
        logic [7:0]        edge_threshold;
        logic [15:0]       edge_holdoff_us;
        logic [TIME_W-1:0] adjust_interval_us;
        logic [6:0]        margin_steps;
        logic [RES_W-1:0]  full_scale_steps;
        logic              correction_enable;
    } cfg_t;

endpackage

FILE: rtl/core/epc_in_if.sv
// epc_in_if: valid/ready channel carrying one input word
// depends on epc_pkg
`timescale 1ns / 1ps

interface epc_in_if;
    import epc_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/epc_out_if.sv
// epc_out_if: valid/ready channel carrying one result word
// depends on epc_pkg
`timescale 1ns / 1ps

interface epc_out_if;
    import epc_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/epc_cfg_if.sv
// epc_cfg_if: configuration write channel with register index and data
// depends on epc_pkg
`timescale 1ns / 1ps

interface epc_cfg_if;
    import epc_pkg::*;

    logic             valid;
    logic             ready;
    cfg_idx_t         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/epc_cfg_regs.sv
// epc_cfg_regs: configuration register file, written one register per word
// depends on epc_pkg and epc_cfg_if
`timescale 1ns / 1ps

module epc_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    epc_cfg_if.sink        cfg,
    output epc_pkg::cfg_t  regs
);
    import epc_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TARGET_PERIOD:   regs_next.target_period_us   = cfg.data[15:0];
                CFG_ERROR_PERCENT:   regs_next.error_percent      = cfg.data[5:0];
                CFG_EDGE_THRESHOLD:  regs_next.edge_threshold     = cfg.data[7:0];
                CFG_EDGE_HOLDOFF:    regs_next.edge_holdoff_us    = cfg.data[15:0];
                CFG_ADJUST_INTERVAL: regs_next.adjust_interval_us = cfg.data[TIME_W-1:0];
                CFG_MARGIN_STEPS:    regs_next.margin_steps       = cfg.data[6:0];
                CFG_FULL_SCALE:      regs_next.full_scale_steps   = cfg.data[RES_W-1:0];
                CFG_CORR_ENABLE:     regs_next.correction_enable  = cfg.data[0];
                default:             regs_next = regs_reg;
            endcase
        end
    end

    // register state with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.target_period_us   <= 16'd2273;
            regs_reg.error_percent      <= 6'd2;
            regs_reg.edge_threshold     <= 8'd128;
            regs_reg.edge_holdoff_us    <= 16'd100;
            regs_reg.adjust_interval_us <= 20'd10000;
            regs_reg.margin_steps       <= 7'd10;
            regs_reg.full_scale_steps   <= 10'd768;
            regs_reg.correction_enable  <= 1'b1;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: rtl/core/epc_step.sv
// epc_step: per-sample state and single-pass edge, averaging and correction logic
// depends on epc_pkg; state advances on each fire pulse
`timescale 1ns / 1ps

module epc_step #(
    parameter int READINGS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  epc_pkg::in_word_t   word,
    input  epc_pkg::cfg_t       regs,
    output epc_pkg::out_word_t  result
);
    import epc_pkg::*;

    localparam int CNT_W = $clog2(READINGS + 1);
    localparam int SUM_W = TIME_W + $clog2(READINGS);

    // state registers
    logic [8:0]        prev_level_reg,   prev_level_next;
    logic [TIME_W-1:0] since_edge_reg,   since_edge_next;
    logic [TIME_W-1:0] since_adjust_reg, since_adjust_next;
    logic [CNT_W-1:0]  count_reg,        count_next;
    logic [SUM_W-1:0]  sum_reg,          sum_next;
    logic [TIME_W-1:0] held_reg,         held_next;
    logic [RES_W-1:0]  res_reg,          res_next;

    // intermediate values
    logic [RES_W-1:0]  res_load;
    logic [TIME_W:0]   edge_add, adjust_add;
    logic [TIME_W-1:0] edge_sat, adjust_sat;
    logic              active, past_holdoff, edge_hit, store_room, full, adjust_due;
    logic [CNT_W-1:0]  count0, count1;
    logic [SUM_W-1:0]  sum0, sum1, avg_full;
    logic [TIME_W-1:0] held_now;
    logic [7:0]        lo_factor, hi_factor;
    logic [BAND_W-1:0] lo_prod, hi_prod;
    logic [CMP_W-1:0]  held_x100;
    logic              too_short, too_long;
    logic [RES_W-1:0]  upper_limit;
    logic              bottom, top;

    // saturating timers
    assign edge_add   = {1'b0, since_edge_reg} + {{(TIME_W - 9){1'b0}}, word.delta_us};
    assign adjust_add = {1'b0, since_adjust_reg} + {{(TIME_W - 9){1'b0}}, word.delta_us};
    assign edge_sat   = edge_add[TIME_W] ? TIME_MAX : edge_add[TIME_W-1:0];
    assign adjust_sat = adjust_add[TIME_W] ? TIME_MAX : adjust_add[TIME_W-1:0];

    assign res_load = word.load_enable ? word.load_value : res_reg;
    assign active   = regs.correction_enable && word.note_active;

    // edge detection after holdoff
    assign past_holdoff = edge_sat > {{(TIME_W - 16){1'b0}}, regs.edge_holdoff_us};
    assign edge_hit     = active && past_holdoff && (word.sample > regs.edge_threshold)
                          && (prev_level_reg < {1'b0, regs.edge_threshold});

    // period accumulation
    assign count0     = word.restart ? '0 : count_reg;
    assign sum0       = word.restart ? '0 : sum_reg;
    assign store_room = count0 < CNT_W'(READINGS);
    assign count1     = (edge_hit && store_room) ? count0 + CNT_W'(1) : count0;
    assign sum1       = (edge_hit && store_room)
                        ? sum0 + {{(SUM_W - TIME_W){1'b0}}, edge_sat} : sum0;
    assign full       = count1 >= CNT_W'(READINGS);
    assign avg_full   = SUM_W'(sum1 / READINGS);

    // average as it stands after this sample
    assign held_now = (active && full) ? avg_full[TIME_W-1:0] : held_reg;

    // band limits, compared as held*100 against target*(100 -/+ error)
    assign lo_factor = PERCENT - {2'b00, regs.error_percent};
    assign hi_factor = PERCENT + {2'b00, regs.error_percent};
    assign lo_prod   = {8'd0, regs.target_period_us} * {16'd0, lo_factor};
    assign hi_prod   = {8'd0, regs.target_period_us} * {16'd0, hi_factor};
    assign held_x100 = ({{(CMP_W - TIME_W){1'b0}}, held_now} << 6)
                     + ({{(CMP_W - TIME_W){1'b0}}, held_now} << 5)
                     + ({{(CMP_W - TIME_W){1'b0}}, held_now} << 2);
    assign too_short = {{(CMP_W - BAND_W){1'b0}}, lo_prod} >= held_x100 + CMP_W'(PERCENT);
    assign too_long  = {{(CMP_W - BAND_W){1'b0}}, hi_prod} < held_x100;

    assign adjust_due  = active && (adjust_sat > regs.adjust_interval_us);
    assign upper_limit = (regs.full_scale_steps >= {3'b000, regs.margin_steps})
                         ? regs.full_scale_steps - {3'b000, regs.margin_steps} : '0;

    // next state and result
    always_comb
    begin
        prev_level_next   = prev_level_reg;
        since_edge_next   = edge_hit ? '0 : edge_sat;
        since_adjust_next = adjust_sat;
        count_next        = count_reg;
        sum_next          = sum_reg;
        held_next         = held_reg;
        res_next          = res_load;
        bottom            = 1'b0;
        top               = 1'b0;

        if (active)
        begin
            if (past_holdoff)
            begin
                prev_level_next = {1'b0, word.sample};
            end
            if (full)
            begin
                held_next  = avg_full[TIME_W-1:0];
                count_next = '0;
                sum_next   = '0;
            end
            else
            begin
                count_next = count1;
                sum_next   = sum1;
            end
        end

        if (adjust_due && too_short)
        begin
            since_adjust_next = '0;
            if (res_load <= {3'b000, regs.margin_steps})
            begin
                res_next = {3'b000, regs.margin_steps};
                bottom   = 1'b1;
            end
            else
            begin
                res_next = res_load - RES_W'(1);
            end
        end
        else if (adjust_due && too_long)
        begin
            since_adjust_next = '0;
            if (res_load >= upper_limit)
            begin
                res_next = upper_limit;
                top      = 1'b1;
            end
            else
            begin
                res_next = res_load + RES_W'(1);
            end
        end

        result.resistance     = res_next;
        result.average_period = held_next;
        result.edge_seen      = edge_hit;
        result.new_average    = active && full;
        result.bottomed_out   = bottom;
        result.topped_out     = top;
    end

    // state update on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg   <= 9'h100;
            since_edge_reg   <= '0;
            since_adjust_reg <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            held_reg         <= '0;
            res_reg          <= '0;
        end
        else if (fire)
        begin
            prev_level_reg   <= prev_level_next;
            since_edge_reg   <= since_edge_next;
            since_adjust_reg <= since_adjust_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            held_reg         <= held_next;
            res_reg          <= res_next;
        end
    end

endmodule

FILE: rtl/core/edge_period_pitch_corrector.sv
// edge_period_pitch_corrector: a sample taken into the input register feeding
// epc_step has its result registered in the result register, which shows valid;
// one sample is taken per cycle, sustained, while the receiver takes results.
// rst_n clears all control and measurement state asynchronously and restores
// the configuration defaults; the block takes words from the first edge after.
`timescale 1ns / 1ps

module edge_period_pitch_corrector #(
    parameter int READINGS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    epc_in_if.sink    feed,
    epc_out_if.source result,
    epc_cfg_if.sink   cfg
);
    import epc_pkg::*;

    cfg_t      regs;
    out_word_t step_word;

    logic      in_vld_reg,  in_vld_next;
    in_word_t  in_word_reg;
    logic      out_vld_reg, out_vld_next;
    out_word_t out_word_reg;
    logic      advance, fire, take;

    // handshake control
    assign advance      = !out_vld_reg || result.ready;
    assign fire         = in_vld_reg && advance;
    assign feed.ready   = !in_vld_reg || advance;
    assign take         = feed.valid && feed.ready;
    assign result.valid = out_vld_reg;
    assign result.data  = out_word_reg;

    epc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    epc_step #(
        .READINGS (READINGS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (in_word_reg),
        .regs   (regs),
        .result (step_word)
    );

    // stage valid next values
    always_comb
    begin
        in_vld_next  = take ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
        out_vld_next = fire ? 1'b1 : (result.ready ? 1'b0 : out_vld_reg);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= feed.data;
        end
        if (fire)
        begin
            out_word_reg <= step_word;
        end
    end

endmodule

FILE: rtl/core/epc_checker.sv
// epc_checker: port-level assertions for edge_period_pitch_corrector
// depends on epc_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module epc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input epc_pkg::out_word_t out_data
);
    import epc_pkg::*;

    logic [1:0] inflight_reg, inflight_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // words accepted and not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before it was taken");

    // a waiting result holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result word changed while stalled");

    // no result without an accepted sample behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result offered with no sample in flight");

    // with both stages full a new sample needs the result to leave
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && inflight_reg == 2'd2 |-> out_acc)
        else $error("sample accepted into a full pipeline");

endmodule

bind edge_period_pitch_corrector epc_checker u_epc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (feed.valid),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

FILE: tb/sv/tb.sv
// tb: self-checking bench for edge_period_pitch_corrector with a local predictor
// depends on epc_pkg, epc_in_if, epc_out_if, epc_cfg_if and the block itself
`timescale 1ns / 1ps

module tb;
    import epc_pkg::*;

    localparam int READ_N = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    epc_in_if  feed_bus ();
    epc_out_if result_bus ();
    epc_cfg_if cfg_bus ();

    edge_period_pitch_corrector #(
        .READINGS(READ_N)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // words waiting to be offered and results predicted for them
    in_word_t  sample_backlog[$];
    out_word_t predicted_results[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;
    int tone_thr       = 128;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // predictor copy of the registers, reset values
    logic [15:0] p_target   = 16'd2273;
    logic [5:0]  p_err      = 6'd2;
    logic [7:0]  p_thr      = 8'd128;
    logic [15:0] p_holdoff  = 16'd100;
    logic [19:0] p_interval = 20'd10000;
    logic [6:0]  p_margin   = 7'd10;
    logic [9:0]  p_full     = 10'd768;
    logic        p_enable   = 1'b1;

    // predictor copy of the measurement state
    logic [10:0] last_level  = 11'd1024;
    logic [19:0] edge_timer  = '0;
    logic [19:0] adjust_timer = '0;
    int unsigned set_count   = 0;
    logic [23:0] set_sum     = '0;
    logic [19:0] held_avg    = '0;
    logic [9:0]  res_step    = '0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [19:0] sat_time(logic [19:0] t, logic [9:0] d);
        logic [20:0] s;
        s = {1'b0, t} + 21'(d);
        return (s > 21'(TIME_MAX)) ? TIME_MAX : s[19:0];
    endfunction

    // one sample through the corrector: timers, edge detect, averaging, correction
    function automatic out_word_t predict_sample(in_word_t w);
        out_word_t o;
        logic      crossed;
        logic      fresh;
        logic      bottom;
        logic      top;
        longint    lo_lim;
        longint    hi_lim;
        int        upper;
        int        r;
        crossed = 1'b0;
        fresh   = 1'b0;
        bottom  = 1'b0;
        top     = 1'b0;
        if (w.load_enable)
            res_step = w.load_value;
        edge_timer   = sat_time(edge_timer, w.delta_us);
        adjust_timer = sat_time(adjust_timer, w.delta_us);
        if (p_enable && w.note_active)
        begin
            if (w.restart)
            begin
                set_count = 0;
                set_sum   = '0;
            end
            // level only tracked once the holdoff has run out
            if (edge_timer > p_holdoff)
            begin
                crossed    = (w.sample > p_thr) && (last_level < {3'b000, p_thr});
                last_level = {3'b000, w.sample};
            end
            if (crossed)
            begin
                if (set_count < READ_N)
                begin
                    set_sum   = set_sum + 24'(edge_timer);
                    set_count = set_count + 1;
                end
                edge_timer = '0;
            end
            if (set_count >= READ_N)
            begin
                held_avg  = 20'(set_sum / READ_N);
                set_count = 0;
                set_sum   = '0;
                fresh     = 1'b1;
            end
            // step the resistance when the average leaves the band
            if (adjust_timer > p_interval)
            begin
                lo_lim = longint'(p_target) * (longint'(PERCENT) - longint'(p_err))
                         / longint'(PERCENT);
                hi_lim = longint'(p_target) * (longint'(PERCENT) + longint'(p_err))
                         / longint'(PERCENT);
                upper = int'(p_full) - int'(p_margin);
                if (upper < 0)
                    upper = 0;
                r = int'(res_step);
                if (longint'(held_avg) < lo_lim)
                begin
                    r = r - 1;
                    if (r < int'(p_margin))
                    begin
                        r      = int'(p_margin);
                        bottom = 1'b1;
                    end
                    res_step     = r[9:0];
                    adjust_timer = '0;
                end
                else if (longint'(held_avg) > hi_lim)
                begin
                    r = r + 1;
                    if (r > upper)
                    begin
                        r   = upper;
                        top = 1'b1;
                    end
                    res_step     = r[9:0];
                    adjust_timer = '0;
                end
            end
        end
        o.resistance     = res_step;
        o.average_period = held_avg;
        o.edge_seen      = crossed;
        o.new_average    = fresh;
        o.bottomed_out   = bottom;
        o.topped_out     = top;
        return o;
    endfunction

    // input driver, fed from the backlog
    always @(posedge clk)
    begin
        if (!rst_n)
            feed_bus.valid <= 1'b0;
        else if (!feed_bus.valid || feed_bus.ready)
        begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                feed_bus.valid <= 1'b1;
                feed_bus.data  <= sample_backlog.pop_front();
            end
            else
                feed_bus.valid <= 1'b0;
        end
    end

    // long receiver hold-off countdown
    always @(posedge clk)
    begin
        if (hold_len > 0)
            hold_len <= hold_len - 1;
    end

    // result ready with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= (hold_len == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    // register writes update the predictor
    always @(posedge clk)
    begin
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                CFG_TARGET_PERIOD:   p_target   = cfg_bus.data[15:0];
                CFG_ERROR_PERCENT:   p_err      = cfg_bus.data[5:0];
                CFG_EDGE_THRESHOLD:  p_thr      = cfg_bus.data[7:0];
                CFG_EDGE_HOLDOFF:    p_holdoff  = cfg_bus.data[15:0];
                CFG_ADJUST_INTERVAL: p_interval = cfg_bus.data[19:0];
                CFG_MARGIN_STEPS:    p_margin   = cfg_bus.data[6:0];
                CFG_FULL_SCALE:      p_full     = cfg_bus.data[9:0];
                CFG_CORR_ENABLE:     p_enable   = cfg_bus.data[0];
                default: ;
            endcase
        end
    end

    // monitor: predict accepted words, check accepted results
    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t got;
        if (rst_n && feed_bus.valid && feed_bus.ready)
            predicted_results.push_back(predict_sample(feed_bus.data));
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.data;
            if (predicted_results.size() == 0)
            begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.resistance !== want.resistance)
                begin
                    $error("resistance: expected %0d, got %0d", want.resistance,
                           got.resistance);
                    mismatch_count++;
                end
                if (got.average_period !== want.average_period)
                begin
                    $error("average_period: expected %0d, got %0d", want.average_period,
                           got.average_period);
                    mismatch_count++;
                end
                if (got.edge_seen !== want.edge_seen)
                begin
                    $error("edge_seen: expected %0b, got %0b", want.edge_seen,
                           got.edge_seen);
                    mismatch_count++;
                end
                if (got.new_average !== want.new_average)
                begin
                    $error("new_average: expected %0b, got %0b", want.new_average,
                           got.new_average);
                    mismatch_count++;
                end
                if (got.bottomed_out !== want.bottomed_out)
                begin
                    $error("bottomed_out: expected %0b, got %0b", want.bottomed_out,
                           got.bottomed_out);
                    mismatch_count++;
                end
                if (got.topped_out !== want.topped_out)
                begin
                    $error("topped_out: expected %0b, got %0b", want.topped_out,
                           got.topped_out);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[edge_period_pitch_corrector] ERROR");
            $finish;
        end
    end

    task automatic push_word(int s, int d, bit act, bit rs, bit ld, int lv);
        in_word_t w;
        w.sample      = 8'(s);
        w.delta_us    = 10'(d);
        w.note_active = act;
        w.restart     = rs;
        w.load_enable = ld;
        w.load_value  = 10'(lv);
        sample_backlog.push_back(w);
    endtask

    // square-ish tones around the threshold, with some noise words mixed in
    task automatic fill_tones(int count, int hmin, int hmax, int dlo, int dhi);
        int       left;
        int       burst;
        int       half;
        int       i;
        int       lo_s;
        int       hi_s;
        in_word_t w;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(24 * hmax, 8 * hmax);
            half  = $urandom_range(hmax, hmin);
            for (i = 0; i < burst && left > 0; i++)
            begin
                hi_s = (tone_thr >= 255) ? 255 : $urandom_range(255, tone_thr + 1);
                lo_s = (tone_thr == 0) ? 0 : $urandom_range(tone_thr - 1, 0);
                w.sample      = 8'(((i / half) % 2 == 0) ? lo_s : hi_s);
                w.delta_us    = 10'($urandom_range(dhi, dlo));
                w.note_active = ($urandom_range(99) >= 3);
                w.restart     = (i == 0) || ($urandom_range(299) == 0);
                w.load_enable = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 2);
                w.load_value  = 10'($urandom_range(1023));
                if ($urandom_range(99) < 8)
                    w = in_word_t'($urandom_range(32'h3FFFFFFF));
                sample_backlog.push_back(w);
                left--;
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_W'(val);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic program_regs(int tgt, int pct, int thr, int hold, int intv, int marg,
                                int full, int en);
        write_reg(CFG_TARGET_PERIOD, tgt);
        write_reg(CFG_ERROR_PERCENT, pct);
        write_reg(CFG_EDGE_THRESHOLD, thr);
        write_reg(CFG_EDGE_HOLDOFF, hold);
        write_reg(CFG_ADJUST_INTERVAL, intv);
        write_reg(CFG_MARGIN_STEPS, marg);
        write_reg(CFG_FULL_SCALE, full);
        write_reg(CFG_CORR_ENABLE, en);
        tone_thr = thr;
    endtask

    // wait until every offered word has its result back, then let the block settle
    task automatic settle();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || feed_bus.valid || predicted_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int k;
        rst_n            = 1'b0;
        feed_bus.valid   = 1'b0;
        feed_bus.data    = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_TARGET_PERIOD;
        cfg_bus.data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on reset settings
        push_word(0, 0, 1, 0, 1, 0);          // load zero, holdoff not over yet
        push_word(0, 1023, 1, 0, 0, 0);       // level drops below threshold
        push_word(255, 1023, 1, 0, 0, 0);     // rising crossing, first reading
        push_word(0, 50, 1, 0, 0, 0);         // inside holdoff: level kept
        push_word(255, 30, 1, 0, 0, 0);       // still inside holdoff: no crossing
        push_word(0, 1023, 1, 0, 0, 0);
        push_word(128, 10, 1, 0, 0, 0);       // equal to threshold: no crossing
        push_word(255, 1023, 1, 0, 0, 0);     // previous level not below threshold
        push_word(0, 1023, 1, 1, 0, 0);       // restart drops the partial set
        push_word(129, 1023, 1, 0, 0, 0);     // just above threshold
        push_word(127, 1023, 0, 0, 0, 0);     // no note: timers only
        push_word(0, 1023, 0, 0, 1, 1023);    // load full scale while idle
        push_word(0, 1023, 1, 0, 0, 0);
        push_word(255, 1023, 1, 1, 0, 0);     // restart with a rising crossing
        push_word(0, 1023, 1, 0, 1, 0);       // load zero again
        for (k = 0; k < 10; k++)
            push_word((k % 2) ? 255 : 0, 1023, 1, 0, 0, 0);  // steps below margin
        settle();

        // nominal band, no idling
        program_regs(2273, 2, 128, 100, 3000, 10, 768, 1);
        fill_tones(260, 1, 5, 150, 450);
        settle();

        // short target, zero margin, zero adjust interval, sender idles
        src_idle_pct = 49;
        program_regs(400, 5, 60, 50, 0, 0, 1023, 1);
        fill_tones(260, 1, 4, 20, 120);
        settle();

        // widest band, margin above full scale, receiver stalls
        src_idle_pct   = 0;
        sink_stall_pct = 49;
        program_regs(65535, 63, 1, 0, 2000, 127, 1, 1);
        fill_tones(230, 1, 3, 0, 1023);
        settle();

        // zero target and band, zero full scale: every step tops out
        src_idle_pct   = 7;
        sink_stall_pct = 7;
        program_regs(0, 0, 200, 1000, 100, 64, 0, 1);
        fill_tones(260, 2, 6, 100, 600);
        settle();

        // correction disabled, receiver held off while the sender keeps offering
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = 300;
        program_regs(1000, 50, 0, 200, 1048575, 20, 40, 0);
        fill_tones(260, 1, 5, 0, 1023);
        settle();

        // longest holdoff, long periods
        src_idle_pct   = 49;
        sink_stall_pct = 49;
        program_regs(5000, 20, 254, 65535, 20000, 5, 1000, 1);
        fill_tones(400, 35, 40, 1000, 1023);
        settle();

        if (mismatch_count == 0)
            $display("[edge_period_pitch_corrector] OK");
        else
            $display("[edge_period_pitch_corrector] ERROR");
        $finish;
    end

endmodule
